// ----- rtl/udbf_pkg.sv -----
// Package for the UART dual byte FIFO: field widths, codes, payload and control types.
// Used by every other file of the block except udbf_chan_if; depends on nothing.
`timescale 1ns / 1ps

package udbf_pkg;

   localparam int RX_DEPTH_DEF = 256;
   localparam int TX_DEPTH_DEF = 256;

   localparam int DATA_W     = 8;
   localparam int CMD_W      = 3;
   localparam int LOG2_W     = 4;
   localparam int CNT_W      = 9;
   localparam int DROP_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [LOG2_W-1:0] RX_SIZE_LOG2_RST = 4'd8;
   localparam logic [LOG2_W-1:0] TX_SIZE_LOG2_RST = 4'd8;
   localparam logic              TX_ENABLE_RST    = 1'b1;
   localparam logic              AUTO_PUMP_RST    = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_RX_PUSH  = 3'd0,
      CMD_RX_READ  = 3'd1,
      CMD_TX_WRITE = 3'd2,
      CMD_TX_TICK  = 3'd3,
      CMD_TX_POP   = 3'd4,
      CMD_DROPS    = 3'd5,
      CMD_RESET    = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_READY = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RX_SIZE_LOG2 = 2'd0,
      CSR_TX_ENABLE    = 2'd1,
      CSR_TX_SIZE_LOG2 = 2'd2,
      CSR_AUTO_PUMP    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_RX   = 2'd1,
      RD_TX   = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic [LOG2_W-1:0] rx_size_log2;
      logic              tx_enable;
      logic [LOG2_W-1:0] tx_size_log2;
      logic              auto_pump;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] data_in;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data_out;
      logic                send_valid;
      logic                accepted;
      logic                irq_set_valid;
      logic                irq_set_value;
      logic [CNT_W-1:0]    rx_count;
      logic [CNT_W-1:0]    tx_free;
      logic                tx_busy;
      logic [DROP_W-1:0]   drop_count;
   } rsp_payload_type;

   // Result of one command before the store read data is attached.
   typedef struct packed {
      status_type        status;
      rd_sel_type        rd_sel;
      logic              send_valid;
      logic              accepted;
      logic              irq_set_valid;
      logic              irq_set_value;
      logic [CNT_W-1:0]  rx_count;
      logic [CNT_W-1:0]  tx_free;
      logic              tx_busy;
      logic [DROP_W-1:0] drop_count;
   } step_result_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ----- rtl/udbf_chan_if.sv -----
// Valid/ready channel carrying one payload beat per handshake.
// Payload types come from udbf_pkg.
`timescale 1ns / 1ps

interface udbf_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/udbf_ram.sv -----
// Byte store with one write port and one read port with registered read data.
// Depends on udbf_pkg for the data width.
`timescale 1ns / 1ps

module udbf_ram
   import udbf_pkg::*;
#(
   parameter int DEPTH = RX_DEPTH_DEF,
   parameter int AW    = addr_width(RX_DEPTH_DEF)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/udbf_ctrl.sv -----
// Pointer, flag and drop counter state of both FIFOs, and the decode of one command.
// Depends on udbf_pkg; drives the store ports of two udbf_ram instances.
`timescale 1ns / 1ps

module udbf_ctrl
   import udbf_pkg::*;
#(
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF,
   parameter int RX_AW    = addr_width(RX_DEPTH_DEF),
   parameter int TX_AW    = addr_width(TX_DEPTH_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              accept,
   input  logic [CMD_W-1:0]  cmd,
   input  logic [DATA_W-1:0] data_in,
   output logic              rx_wr_en,
   output logic [RX_AW-1:0]  rx_wr_addr,
   output logic              rx_rd_en,
   output logic [RX_AW-1:0]  rx_rd_addr,
   output logic              tx_wr_en,
   output logic [TX_AW-1:0]  tx_wr_addr,
   output logic              tx_rd_en,
   output logic [TX_AW-1:0]  tx_rd_addr,
   output logic [DATA_W-1:0] wr_data,
   output step_result_type   result
);

   // One spare pointer bit so that a full FIFO is told apart from an empty one.
   localparam int RX_PW     = $clog2(RX_DEPTH) + 1;
   localparam int TX_PW     = $clog2(TX_DEPTH) + 1;
   localparam int RX_MAX_LG = $clog2(RX_DEPTH + 1) - 1;
   localparam int TX_MAX_LG = $clog2(TX_DEPTH + 1) - 1;

   logic [RX_PW-1:0]  rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [TX_PW-1:0]  tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic              tx_active_ff, tx_active_in;
   logic [DROP_W-1:0] drops_ff, drops_in;

   logic [LOG2_W-1:0] rx_cap_lg, tx_cap_lg;
   logic [RX_PW-1:0]  rx_cap, rx_mask, rx_fill, rx_fill_after;
   logic [TX_PW-1:0]  tx_cap, tx_mask, tx_fill, tx_fill_after, tx_free_full;

   // Capacity in use is clamped to the largest power of two that fits the store.
   assign rx_cap_lg = (cfg.rx_size_log2 > LOG2_W'(RX_MAX_LG)) ?
                      LOG2_W'(RX_MAX_LG) : cfg.rx_size_log2;
   assign tx_cap_lg = (cfg.tx_size_log2 > LOG2_W'(TX_MAX_LG)) ?
                      LOG2_W'(TX_MAX_LG) : cfg.tx_size_log2;
   assign rx_cap  = RX_PW'(1) << rx_cap_lg;
   assign tx_cap  = TX_PW'(1) << tx_cap_lg;
   assign rx_mask = rx_cap - RX_PW'(1);
   assign tx_mask = tx_cap - TX_PW'(1);
   assign rx_fill = rx_wr_ff - rx_rd_ff;
   assign tx_fill = tx_wr_ff - tx_rd_ff;

   assign rx_wr_addr = rx_wr_ff[RX_AW-1:0] & rx_mask[RX_AW-1:0];
   assign rx_rd_addr = rx_rd_ff[RX_AW-1:0] & rx_mask[RX_AW-1:0];
   assign tx_wr_addr = tx_wr_ff[TX_AW-1:0] & tx_mask[TX_AW-1:0];
   assign tx_rd_addr = tx_rd_ff[TX_AW-1:0] & tx_mask[TX_AW-1:0];
   assign wr_data    = data_in;

   always_comb begin
      rx_wr_in     = rx_wr_ff;
      rx_rd_in     = rx_rd_ff;
      tx_wr_in     = tx_wr_ff;
      tx_rd_in     = tx_rd_ff;
      tx_active_in = tx_active_ff;
      drops_in     = drops_ff;
      rx_wr_en     = 1'b0;
      rx_rd_en     = 1'b0;
      tx_wr_en     = 1'b0;
      tx_rd_en     = 1'b0;

      result               = '0;
      result.status        = ST_OK;
      result.rd_sel        = RD_NONE;

      if (accept) begin
         case (cmd)
            CMD_RX_PUSH: begin
               if (rx_fill < rx_cap) begin
                  rx_wr_en        = 1'b1;
                  rx_wr_in        = rx_wr_ff + RX_PW'(1);
                  result.accepted = 1'b1;
               end else begin
                  drops_in = drops_ff + DROP_W'(1);
               end
            end
            CMD_RX_READ: begin
               if (rx_fill == '0) begin
                  result.status = ST_EMPTY;
               end else begin
                  rx_rd_en      = 1'b1;
                  rx_rd_in      = rx_rd_ff + RX_PW'(1);
                  result.rd_sel = RD_RX;
               end
            end
            CMD_TX_WRITE: begin
               if (!cfg.tx_enable) begin
                  result.status = ST_NOT_READY;
               end else if (tx_fill < tx_cap) begin
                  tx_wr_en        = 1'b1;
                  tx_wr_in        = tx_wr_ff + TX_PW'(1);
                  result.accepted = 1'b1;
                  // With auto pump on, a write into an empty FIFO starts interrupt-driven sending.
                  if (cfg.auto_pump && tx_fill == '0) begin
                     tx_active_in         = 1'b1;
                     result.irq_set_valid = 1'b1;
                     result.irq_set_value = 1'b1;
                  end
               end
            end
            CMD_TX_TICK: begin
               if (!cfg.tx_enable || !cfg.auto_pump) begin
                  result.status = ST_NOT_READY;
               end else begin
                  if (tx_fill == '0) begin
                     result.status = ST_EMPTY;
                  end else begin
                     tx_rd_en          = 1'b1;
                     tx_rd_in          = tx_rd_ff + TX_PW'(1);
                     result.rd_sel     = RD_TX;
                     result.send_valid = 1'b1;
                  end
                  // The enable drops once the tick leaves nothing to send.
                  if (tx_fill <= TX_PW'(1)) begin
                     tx_active_in         = 1'b0;
                     result.irq_set_valid = 1'b1;
                     result.irq_set_value = 1'b0;
                  end
               end
            end
            CMD_TX_POP: begin
               if (!cfg.tx_enable) begin
                  result.status = ST_NOT_READY;
               end else if (tx_fill == '0) begin
                  result.status = ST_EMPTY;
               end else begin
                  tx_rd_en      = 1'b1;
                  tx_rd_in      = tx_rd_ff + TX_PW'(1);
                  result.rd_sel = RD_TX;
               end
            end
            CMD_DROPS: begin
               result.drop_count = drops_ff;
               drops_in          = '0;
            end
            CMD_RESET: begin
               rx_wr_in     = '0;
               rx_rd_in     = '0;
               tx_wr_in     = '0;
               tx_rd_in     = '0;
               tx_active_in = 1'b0;
               drops_in     = '0;
            end
            default: begin
            end
         endcase
      end

      rx_fill_after  = rx_wr_in - rx_rd_in;
      tx_fill_after  = tx_wr_in - tx_rd_in;
      tx_free_full   = tx_cap - tx_fill_after;
      result.rx_count = CNT_W'(rx_fill_after);
      result.tx_free  = (cfg.tx_enable && tx_fill_after < tx_cap) ?
                        CNT_W'(tx_free_full) : '0;
      result.tx_busy  = cfg.tx_enable && (tx_fill_after != '0 || tx_active_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ff     <= '0;
         rx_rd_ff     <= '0;
         tx_wr_ff     <= '0;
         tx_rd_ff     <= '0;
         tx_active_ff <= 1'b0;
         drops_ff     <= '0;
      end else begin
         rx_wr_ff     <= rx_wr_in;
         rx_rd_ff     <= rx_rd_in;
         tx_wr_ff     <= tx_wr_in;
         tx_rd_ff     <= tx_rd_in;
         tx_active_ff <= tx_active_in;
         drops_ff     <= drops_in;
      end
   end

endmodule

// ----- rtl/uart_dual_byte_fifo_unit.sv -----
// UART dual byte FIFO: receive FIFO, optional transmit FIFO, drop counter, send control.
// Each result passes stage one, then the output register, before its beat leaves.
// Throughput: one command per cycle while not stalled; each does at most one store read or write.
// Reset clears pointers, transmit flag, drop count and pipeline valids; the
// configuration returns to 8, 1, 8, 1. Store contents are not cleared.
`timescale 1ns / 1ps

module uart_dual_byte_fifo_unit
   import udbf_pkg::*;
#(
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   udbf_chan_if.sink             req_chan,
   udbf_chan_if.source           rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int RX_AW = addr_width(RX_DEPTH);
   localparam int TX_AW = addr_width(TX_DEPTH);

   cfg_type         cfg_ff, cfg_in;
   req_payload_type req_beat;
   step_result_type step_res;
   step_result_type s1_ff;
   logic            s1_valid_ff, s1_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            out_valid_ff, out_valid_in;
   logic            accept, advance;

   logic              rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [RX_AW-1:0]  rx_wr_addr, rx_rd_addr;
   logic [TX_AW-1:0]  tx_wr_addr, tx_rd_addr;
   logic [DATA_W-1:0] wr_data, rx_rd_data, tx_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RX_SIZE_LOG2: cfg_in.rx_size_log2 = csr_wr_data;
            CSR_TX_ENABLE:    cfg_in.tx_enable    = csr_wr_data[0];
            CSR_TX_SIZE_LOG2: cfg_in.tx_size_log2 = csr_wr_data;
            CSR_AUTO_PUMP:    cfg_in.auto_pump    = csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Stage one holds the decoded result while the store read completes.
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_beat       = req_chan.payload;

   udbf_ctrl #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH),
      .RX_AW    (RX_AW),
      .TX_AW    (TX_AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .cmd        (req_beat.cmd),
      .data_in    (req_beat.data_in),
      .rx_wr_en   (rx_wr_en),
      .rx_wr_addr (rx_wr_addr),
      .rx_rd_en   (rx_rd_en),
      .rx_rd_addr (rx_rd_addr),
      .tx_wr_en   (tx_wr_en),
      .tx_wr_addr (tx_wr_addr),
      .tx_rd_en   (tx_rd_en),
      .tx_rd_addr (tx_rd_addr),
      .wr_data    (wr_data),
      .result     (step_res)
   );

   udbf_ram #(
      .DEPTH (RX_DEPTH),
      .AW    (RX_AW)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (wr_data),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   udbf_ram #(
      .DEPTH (TX_DEPTH),
      .AW    (TX_AW)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (wr_data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

      out_in               = out_ff;
      if (advance) begin
         out_in.status        = s1_ff.status;
         out_in.send_valid    = s1_ff.send_valid;
         out_in.accepted      = s1_ff.accepted;
         out_in.irq_set_valid = s1_ff.irq_set_valid;
         out_in.irq_set_value = s1_ff.irq_set_value;
         out_in.rx_count      = s1_ff.rx_count;
         out_in.tx_free       = s1_ff.tx_free;
         out_in.tx_busy       = s1_ff.tx_busy;
         out_in.drop_count    = s1_ff.drop_count;
         case (s1_ff.rd_sel)
            RD_RX:   out_in.data_out = rx_rd_data;
            RD_TX:   out_in.data_out = tx_rd_data;
            default: out_in.data_out = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rx_size_log2 <= RX_SIZE_LOG2_RST;
         cfg_ff.tx_enable    <= TX_ENABLE_RST;
         cfg_ff.tx_size_log2 <= TX_SIZE_LOG2_RST;
         cfg_ff.auto_pump    <= AUTO_PUMP_RST;
         s1_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= step_res;
      end
      out_ff <= out_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for uart_dual_byte_fifo_unit: directed corner cases, phased random
// traffic with stalls, register changes between phases and a receive overflow burst.
// Depends on udbf_pkg, udbf_chan_if and the block itself.
`timescale 1ns / 1ps

module tb;
   import udbf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 40;
   localparam int RANDOM_PHASES  = 13;
   localparam int PHASE_ITEMS    = 100;
   localparam int OVERFLOW_ITEMS = 12;

   class fifo_pair_model;
      logic [DATA_W-1:0] rx_bytes [RX_DEPTH_DEF];
      logic [DATA_W-1:0] tx_bytes [TX_DEPTH_DEF];
      bit                rx_written [RX_DEPTH_DEF];
      bit                tx_written [TX_DEPTH_DEF];
      logic [15:0]       rx_wr, rx_rd, tx_wr, tx_rd;
      logic              tx_active;
      logic [DROP_W-1:0] rx_drops;
      cfg_type           cfg;
      rsp_payload_type   pending_results [$];
      int                errors, checked, taken, refused, irq_changes;

      function new();
         cfg.rx_size_log2 = RX_SIZE_LOG2_RST;
         cfg.tx_enable    = TX_ENABLE_RST;
         cfg.tx_size_log2 = TX_SIZE_LOG2_RST;
         cfg.auto_pump    = AUTO_PUMP_RST;
         clear_pointers();
         errors = 0;
         checked = 0;
         taken = 0;
         refused = 0;
         irq_changes = 0;
      endfunction

      function void clear_pointers();
         rx_wr = '0;
         rx_rd = '0;
         tx_wr = '0;
         tx_rd = '0;
         tx_active = 1'b0;
         rx_drops = '0;
      endfunction

      // Requested capacity, clipped to the largest power of two the array holds.
      function int unsigned capacity(logic [LOG2_W-1:0] lg, int depth);
         int unsigned c;
         c = 1;
         for (int i = 0; i < lg; i++) begin
            if (c * 2 > depth) break;
            c = c * 2;
         end
         return c;
      endfunction

      function int unsigned rx_cap();
         return capacity(cfg.rx_size_log2, RX_DEPTH_DEF);
      endfunction

      function int unsigned tx_cap();
         return capacity(cfg.tx_size_log2, TX_DEPTH_DEF);
      endfunction

      function int unsigned rx_fill();
         logic [15:0] d;
         d = rx_wr - rx_rd;
         return d;
      endfunction

      function int unsigned tx_fill();
         logic [15:0] d;
         d = tx_wr - tx_rd;
         return d;
      endfunction

      function int unsigned rx_slot(logic [15:0] pos);
         return pos & (rx_cap() - 1);
      endfunction

      function int unsigned tx_slot(logic [15:0] pos);
         return pos & (tx_cap() - 1);
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_RX_SIZE_LOG2: cfg.rx_size_log2 = value;
            CSR_TX_ENABLE:    cfg.tx_enable = value[0];
            CSR_TX_SIZE_LOG2: cfg.tx_size_log2 = value;
            CSR_AUTO_PUMP:    cfg.auto_pump = value[0];
            default: ;
         endcase
      endfunction

      // After a capacity change the slot under the read pointer may never have been
      // written; such a read has no defined answer and must not be issued.
      function bit read_is_safe(logic [CMD_W-1:0] cmd);
         if (cmd == CMD_RX_READ)
            return rx_fill() == 0 || rx_written[rx_slot(rx_rd)];
         if (cmd == CMD_TX_TICK || cmd == CMD_TX_POP)
            return tx_fill() == 0 || tx_written[tx_slot(tx_rd)];
         return 1'b1;
      endfunction

      function void take_command(req_payload_type req);
         rsp_payload_type want;
         int unsigned     slot, tfree;
         bit              kick;
         want = '0;
         taken++;
         case (req.cmd)
            CMD_RX_PUSH: begin
               if (rx_fill() < rx_cap()) begin
                  slot = rx_slot(rx_wr);
                  rx_bytes[slot] = req.data_in;
                  rx_written[slot] = 1'b1;
                  rx_wr++;
                  want.accepted = 1'b1;
               end else begin
                  rx_drops++;
                  refused++;
               end
            end
            CMD_RX_READ: begin
               if (rx_fill() == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  want.data_out = rx_bytes[rx_slot(rx_rd)];
                  rx_rd++;
               end
            end
            CMD_TX_WRITE: begin
               if (!cfg.tx_enable) begin
                  want.status = ST_NOT_READY;
               end else if (tx_fill() < tx_cap()) begin
                  kick = cfg.auto_pump && tx_fill() == 0;
                  slot = tx_slot(tx_wr);
                  tx_bytes[slot] = req.data_in;
                  tx_written[slot] = 1'b1;
                  tx_wr++;
                  want.accepted = 1'b1;
                  if (kick) begin
                     tx_active = 1'b1;
                     want.irq_set_valid = 1'b1;
                     want.irq_set_value = 1'b1;
                     irq_changes++;
                  end
               end else begin
                  refused++;
               end
            end
            CMD_TX_TICK: begin
               if (!cfg.tx_enable || !cfg.auto_pump) begin
                  want.status = ST_NOT_READY;
               end else begin
                  if (tx_fill() == 0) begin
                     want.status = ST_EMPTY;
                  end else begin
                     want.data_out = tx_bytes[tx_slot(tx_rd)];
                     tx_rd++;
                     want.send_valid = 1'b1;
                  end
                  // The enable drops even when the tick found nothing to send.
                  if (tx_fill() == 0) begin
                     tx_active = 1'b0;
                     want.irq_set_valid = 1'b1;
                     irq_changes++;
                  end
               end
            end
            CMD_TX_POP: begin
               if (!cfg.tx_enable) begin
                  want.status = ST_NOT_READY;
               end else if (tx_fill() == 0) begin
                  want.status = ST_EMPTY;
               end else begin
                  want.data_out = tx_bytes[tx_slot(tx_rd)];
                  tx_rd++;
               end
            end
            CMD_DROPS: begin
               want.drop_count = rx_drops;
               rx_drops = '0;
            end
            CMD_RESET: clear_pointers();
            default: ;
         endcase
         tfree = (cfg.tx_enable && tx_fill() < tx_cap()) ? tx_cap() - tx_fill() : 0;
         want.rx_count = CNT_W'(rx_fill());
         want.tx_free  = CNT_W'(tfree);
         want.tx_busy  = cfg.tx_enable && (tx_fill() > 0 || tx_active);
         pending_results.push_back(want);
      endfunction

      function void check_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("t=%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void match_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_results.size() == 0) begin
            errors++;
            $display("t=%0t: result beat %h arrived with no command outstanding", $time, got);
            return;
         end
         want = pending_results.pop_front();
         checked++;
         check_field("status", want.status, got.status);
         check_field("data_out", want.data_out, got.data_out);
         check_field("send_valid", want.send_valid, got.send_valid);
         check_field("accepted", want.accepted, got.accepted);
         check_field("irq_set_valid", want.irq_set_valid, got.irq_set_valid);
         check_field("irq_set_value", want.irq_set_value, got.irq_set_value);
         check_field("rx_count", want.rx_count, got.rx_count);
         check_field("tx_free", want.tx_free, got.tx_free);
         check_field("tx_busy", want.tx_busy, got.tx_busy);
         check_field("drop_count", want.drop_count, got.drop_count);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   bit                    req_idle_on, rsp_idle_on;
   int                    hold_request = 0;
   int                    holds_done = 0;
   int                    reg_writes = 0;
   int                    cycles = 0;
   fifo_pair_model        model;

   // Command mix per traffic flavor (fill, drain, mixed); columns follow the command encoding.
   int unsigned mix [3][8] = '{'{35, 8, 35, 8, 4, 6, 1, 3},
                               '{10, 35, 10, 30, 8, 4, 1, 2},
                               '{22, 20, 20, 18, 8, 6, 2, 4}};

   udbf_chan_if #(.payload_type(req_payload_type)) req ();
   udbf_chan_if #(.payload_type(rsp_payload_type)) rsp ();

   uart_dual_byte_fifo_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycles, model.pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) model.take_command(req.payload);
      if (!reset && rsp.valid && rsp.ready) model.match_result(rsp.payload);
   end

   // Result side: random stalls per beat, plus long hold-offs on request.
   initial begin
      int gap;
      rsp.ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp.ready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
            holds_done++;
            @(negedge clock);
         end
         gap = rsp_idle_on ? $urandom_range(0, 10) : 0;
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         @(negedge clock);
      end
   end

   task automatic issue(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (!model.read_is_safe(cmd)) cmd = CMD_RX_PUSH;
      req.valid   <= 1'b1;
      req.payload <= {cmd, data};
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      while (model.pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      model.write_register(idx, value);
      reg_writes++;
   endtask

   // Mask bit i selects the register with index i.
   task automatic apply_settings(logic [3:0] rx_lg, logic [3:0] tx_en, logic [3:0] tx_lg,
                                 logic [3:0] pump, logic [3:0] mask);
      settle();
      if (mask[0]) csr_write(CSR_RX_SIZE_LOG2, rx_lg);
      if (mask[1]) csr_write(CSR_TX_ENABLE, tx_en);
      if (mask[2]) csr_write(CSR_TX_SIZE_LOG2, tx_lg);
      if (mask[3]) csr_write(CSR_AUTO_PUMP, pump);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CMD_W-1:0] pick_command(int flavor);
      int unsigned total, r;
      total = 0;
      for (int i = 0; i < 8; i++) total += mix[flavor][i];
      r = $urandom_range(0, total - 1);
      for (int i = 0; i < 8; i++) begin
         if (r < mix[flavor][i]) return CMD_W'(i);
         r -= mix[flavor][i];
      end
      return CMD_UNUSED;
   endfunction

   // Mostly small capacities so the FIFOs fill; now and then the largest or an oversized one.
   function automatic logic [3:0] pick_log2();
      case ($urandom_range(0, 9))
         0: return 4'd0;
         1: return 4'd8;
         2: return 4'd15;
         3: return 4'($urandom_range(9, 14));
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   // Single-bit registers get random upper bits; the flag is set most of the time.
   function automatic logic [3:0] pick_flag();
      return {3'($urandom_range(0, 7)), 1'($urandom_range(0, 4) != 0)};
   endfunction

   initial begin
      int flavor;
      model = new();
      req.valid   <= 1'b0;
      req.payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wr_data <= '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty FIFOs, then simple traffic at the reset settings.
      issue(CMD_RX_READ, 8'h00);
      issue(CMD_TX_POP, 8'h00);
      issue(CMD_TX_TICK, 8'h00);
      issue(CMD_DROPS, 8'h00);
      issue(CMD_UNUSED, 8'hFF);
      issue(CMD_RX_PUSH, 8'h00);
      issue(CMD_RX_PUSH, 8'hFF);
      issue(CMD_RX_READ, 8'h00);
      issue(CMD_RX_READ, 8'h00);
      issue(CMD_TX_WRITE, 8'hA5);
      issue(CMD_TX_WRITE, 8'h5A);
      issue(CMD_TX_TICK, 8'h00);
      issue(CMD_TX_TICK, 8'h00);
      issue(CMD_TX_WRITE, 8'hFF);
      issue(CMD_TX_POP, 8'h00);
      issue(CMD_RX_PUSH, 8'h3C);
      issue(CMD_RESET, 8'h00);

      // One-entry FIFOs: receive overflow and a refused transmit write.
      apply_settings(4'd0, 4'd1, 4'd0, 4'd1, 4'b1111);
      issue(CMD_RX_PUSH, 8'h55);
      issue(CMD_RX_PUSH, 8'hAA);
      issue(CMD_DROPS, 8'h00);
      issue(CMD_TX_WRITE, 8'h01);
      issue(CMD_TX_WRITE, 8'h02);
      issue(CMD_TX_TICK, 8'h00);

      // Transmit side switched off, oversized capacities.
      apply_settings(4'd15, 4'd0, 4'd15, 4'd0, 4'b1111);
      issue(CMD_TX_WRITE, 8'h81);
      issue(CMD_TX_TICK, 8'h00);
      issue(CMD_TX_POP, 8'h00);

      // Transmit on without interrupt-driven sending.
      apply_settings(4'd8, 4'd1, 4'd8, 4'd0, 4'b0010);
      issue(CMD_TX_TICK, 8'h00);
      issue(CMD_TX_WRITE, 8'h7E);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(pick_log2(), pick_flag(), pick_log2(), pick_flag(),
                        phase == 0 ? 4'hF : 4'($urandom_range(1, 15)));
         flavor = phase % 3;
         req_idle_on = $urandom_range(0, 2) != 0;
         rsp_idle_on = $urandom_range(0, 2) != 0;
         if (phase % 4 == 1) begin
            // Keep offering while results back up so the input side has to stall.
            req_idle_on = 1'b0;
            hold_request = HOLD_CYCLES;
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            issue(pick_command(flavor), 8'($urandom_range(0, 255)));
      end

      // Overflow a one-entry receive FIFO back to back, reading the drop count after each run.
      apply_settings(4'd0, 4'd1, 4'd0, 4'd1, 4'b0001);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      issue(CMD_DROPS, 8'h00);
      for (int lap = 0; lap < 2; lap++) begin
         for (int n = 0; n < OVERFLOW_ITEMS; n++)
            issue(CMD_RX_PUSH, 8'($urandom_range(0, 255)));
         issue(CMD_DROPS, 8'h00);
      end

      settle();
      $display("Covered %0d commands and %0d result beats over %0d register writes.",
               model.taken, model.checked, reg_writes);
      $display("Saw %0d refused pushes, %0d interrupt-enable changes, %0d long hold-offs.",
               model.refused, model.irq_changes, holds_done);
      if (model.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/udbf_pkg.sv
rtl/udbf_chan_if.sv
rtl/udbf_ram.sv
rtl/udbf_ctrl.sv
rtl/uart_dual_byte_fifo_unit.sv
bench/tb.sv
